[src/bgc_pkg.sv]
// Package for the button gesture classifier: event codes, register indexes,
// field widths and the result record. No dependencies.
`timescale 1ns / 1ps

package bgc_pkg;

	localparam int TimeW   = 32;
	localparam int DebW    = 10;
	localparam int MsW     = 16;
	localparam int CountW  = 8;
	localparam int KindW   = 2;
	localparam int RegIdxW = 2;
	localparam int ThrW    = MsW + CountW + 1;

	localparam logic [CountW-1:0] CountMax = '1;

	// Event codes carried in event_kind.
	localparam logic [KindW-1:0] EvPressed  = 2'd0;
	localparam logic [KindW-1:0] EvLong     = 2'd1;
	localparam logic [KindW-1:0] EvReleased = 2'd2;
	localparam logic [KindW-1:0] EvClicked  = 2'd3;

	// Configuration register indexes.
	localparam logic [RegIdxW-1:0] RegDebounce  = 2'd0;
	localparam logic [RegIdxW-1:0] RegLongPress = 2'd1;
	localparam logic [RegIdxW-1:0] RegRepeat    = 2'd2;
	localparam logic [RegIdxW-1:0] RegClickGap  = 2'd3;

	localparam logic [DebW-1:0] DebounceReset  = 10'd50;
	localparam logic [MsW-1:0]  LongPressReset = 16'd1000;
	localparam logic [MsW-1:0]  RepeatReset    = 16'd1000;
	localparam logic [MsW-1:0]  ClickGapReset  = 16'd300;

	typedef struct packed {
		logic [KindW-1:0]  event_kind;
		logic [CountW-1:0] click_tally;
		logic [CountW-1:0] long_count;
		logic [TimeW-1:0]  held_ms;
	} result_t;

endpackage

[src/bgc_if.sv]
// Handshake channels of the button gesture classifier: the tick channel and
// the event channel. Depends on bgc_pkg for field widths.
`timescale 1ns / 1ps

interface bgc_tick_if;
	logic valid;
	logic ready;
	logic pin_level;

	modport source (output valid, output pin_level, input ready);
	modport sink (input valid, input pin_level, output ready);
endinterface

interface bgc_event_if;
	logic                          valid;
	logic                          ready;
	logic [bgc_pkg::KindW-1:0]     event_kind;
	logic [bgc_pkg::CountW-1:0]    click_tally;
	logic [bgc_pkg::CountW-1:0]    long_count;
	logic [bgc_pkg::TimeW-1:0]     held_ms;

	modport source (output valid, output event_kind, output click_tally,
		output long_count, output held_ms, input ready);
	modport sink (input valid, input event_kind, input click_tally,
		input long_count, input held_ms, output ready);
endinterface

[src/button_gesture_classifier_core.sv]
// Top level of the button gesture classifier: debounce, gesture state machine
// and result register. Depends on bgc_pkg and the channels in bgc_if.sv.
`timescale 1ns / 1ps

// How to use this block:
// Every item on tick_in is one millisecond tick that carries the sampled,
// active-low pin level. The block debounces the level and reports press,
// long press (repeated every repeat interval), release with the held time,
// and clicked with the multi-click count on event_out. A tick gives at most
// one event item; most ticks give none.
// A tick item is taken into an input register, and from there the debounce
// and gesture logic evaluate it in a single pass, update the state and load
// the result register, which drives event_out. One tick can be accepted
// every cycle while the receiver does not stall; the rate is set by the
// single-pass state update, whose longest path is the 16 by 8 bit long
// press threshold product and its compare against the hold duration.
// If the receiver stalls with an event pending, the tick in the input
// register waits and tick_in.ready drops until the event is taken; nothing
// is lost or dropped.
// Reset (arst_n low) returns the timers and the gesture state to idle with
// the pin seen as released, and loads the default register values 50, 1000,
// 1000 and 300 ms. Registers are written through write_en, write_index and
// write_data; the user must write only while no tick is in flight (unchecked).
module button_gesture_classifier_core (
	input  logic                          clk,
	input  logic                          arst_n,
	bgc_tick_if.sink                      tick_in,
	bgc_event_if.source                   event_out,
	input  logic                          write_en,
	input  logic [bgc_pkg::RegIdxW-1:0]   write_index,
	input  logic [bgc_pkg::MsW-1:0]       write_data
);

	typedef enum logic [1:0] {
		ST_IDLE     = 2'd0,
		ST_PRESSED  = 2'd1,
		ST_RELEASED = 2'd2
	} gesture_state_t;

	// Configuration registers.
	logic [bgc_pkg::DebW-1:0] debounce_q;
	logic [bgc_pkg::MsW-1:0]  long_press_q;
	logic [bgc_pkg::MsW-1:0]  repeat_q;
	logic [bgc_pkg::MsW-1:0]  click_gap_q;

	// Input stage.
	logic valid_s1;
	logic pin_s1;

	// Debounce and gesture state.
	logic [bgc_pkg::TimeW-1:0]  tick_time_q;
	logic                       last_level_q;
	logic                       edge_pending_q;
	logic [bgc_pkg::TimeW-1:0]  first_edge_q;
	logic [bgc_pkg::TimeW-1:0]  last_edge_q;
	gesture_state_t             state_q;
	logic [bgc_pkg::TimeW-1:0]  press_start_q;
	logic [bgc_pkg::TimeW-1:0]  release_start_q;
	logic [bgc_pkg::CountW-1:0] long_events_q;
	logic [bgc_pkg::CountW-1:0] clicks_q;

	// Result register.
	logic              out_valid_q;
	bgc_pkg::result_t  result_q;

	// Next-state values from the single evaluation pass.
	logic                       edge_seen;
	logic                       pending_n;
	logic [bgc_pkg::TimeW-1:0]  first_edge_n;
	logic [bgc_pkg::TimeW-1:0]  last_edge_n;
	logic [bgc_pkg::TimeW-1:0]  quiet_time;
	logic                       debouncing;
	logic                       trig;
	logic                       pressed;
	logic [bgc_pkg::TimeW-1:0]  press_dur;
	logic [bgc_pkg::ThrW-1:0]   long_thr;
	gesture_state_t             state_n;
	logic [bgc_pkg::TimeW-1:0]  press_start_n;
	logic [bgc_pkg::TimeW-1:0]  release_start_n;
	logic [bgc_pkg::CountW-1:0] long_events_n;
	logic [bgc_pkg::CountW-1:0] clicks_n;
	logic                       fire;
	bgc_pkg::result_t           result_n;

	logic out_free;
	logic advance;

	// The evaluated tick moves on when the result register is free or is
	// being emptied in this cycle.
	assign out_free      = !out_valid_q || event_out.ready;
	assign advance       = valid_s1 && out_free;
	assign tick_in.ready = !valid_s1 || out_free;

	assign event_out.valid       = out_valid_q;
	assign event_out.event_kind  = result_q.event_kind;
	assign event_out.click_tally = result_q.click_tally;
	assign event_out.long_count  = result_q.long_count;
	assign event_out.held_ms     = result_q.held_ms;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= bgc_pkg::DebounceReset;
			long_press_q <= bgc_pkg::LongPressReset;
			repeat_q     <= bgc_pkg::RepeatReset;
			click_gap_q  <= bgc_pkg::ClickGapReset;
		end else if (write_en) begin
			unique case (write_index)
				bgc_pkg::RegDebounce:  debounce_q   <= write_data[bgc_pkg::DebW-1:0];
				bgc_pkg::RegLongPress: long_press_q <= write_data;
				bgc_pkg::RegRepeat:    repeat_q     <= write_data;
				bgc_pkg::RegClickGap:  click_gap_q  <= write_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_in.ready) begin
			valid_s1 <= tick_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_in.ready && tick_in.valid) begin
			pin_s1 <= tick_in.pin_level;
		end
	end

	// Edge detection, then the debounce check. The quiet time is measured
	// from the latest edge, which is this tick when the level just changed.
	always_comb begin
		edge_seen    = pin_s1 != last_level_q;
		pending_n    = edge_pending_q || edge_seen;
		first_edge_n = (edge_seen && !edge_pending_q) ? tick_time_q : first_edge_q;
		last_edge_n  = edge_seen ? tick_time_q : last_edge_q;
		quiet_time   = tick_time_q - last_edge_n;
		debouncing   = pending_n &&
			(quiet_time < {{(bgc_pkg::TimeW-bgc_pkg::DebW){1'b0}}, debounce_q});
		trig         = pending_n && !debouncing;
		pressed      = !pin_s1;
	end

	// Gesture state machine. The long press threshold grows by one repeat
	// interval for every long press already reported in this hold.
	always_comb begin
		press_dur       = tick_time_q - press_start_q;
		long_thr        = bgc_pkg::ThrW'(long_press_q) +
			bgc_pkg::ThrW'(repeat_q) * bgc_pkg::ThrW'(long_events_q);
		state_n         = state_q;
		press_start_n   = press_start_q;
		release_start_n = release_start_q;
		long_events_n   = long_events_q;
		clicks_n        = clicks_q;
		fire            = 1'b0;
		result_n        = '0;

		unique case (state_q)
			ST_PRESSED: begin
				if (trig && !pressed) begin
					release_start_n      = first_edge_n;
					fire                 = 1'b1;
					result_n.event_kind  = bgc_pkg::EvReleased;
					result_n.click_tally = clicks_q;
					result_n.long_count  = long_events_q;
					result_n.held_ms     = first_edge_n - press_start_q;
					// A hold that produced long presses ends the sequence
					// without a click report.
					state_n = (long_events_q != '0) ? ST_IDLE : ST_RELEASED;
				end else if (!debouncing && pressed && long_events_q != bgc_pkg::CountMax
					&& press_dur >= {{(bgc_pkg::TimeW-bgc_pkg::ThrW){1'b0}}, long_thr}) begin
					long_events_n        = long_events_q + 1'b1;
					fire                 = 1'b1;
					result_n.event_kind  = bgc_pkg::EvLong;
					result_n.click_tally = clicks_q;
					result_n.long_count  = long_events_n;
					result_n.held_ms     = press_dur;
				end
			end
			ST_RELEASED: begin
				if (trig && pressed) begin
					state_n       = ST_PRESSED;
					press_start_n = first_edge_n;
					if (clicks_q != bgc_pkg::CountMax) begin
						clicks_n = clicks_q + 1'b1;
					end
					fire                 = 1'b1;
					result_n.event_kind  = bgc_pkg::EvPressed;
					result_n.click_tally = clicks_n;
					result_n.long_count  = long_events_q;
				end else if (!debouncing && !pressed &&
					(tick_time_q - release_start_q) >=
					{{(bgc_pkg::TimeW-bgc_pkg::MsW){1'b0}}, click_gap_q}) begin
					state_n              = ST_IDLE;
					fire                 = 1'b1;
					result_n.event_kind  = bgc_pkg::EvClicked;
					result_n.click_tally = clicks_q;
				end
			end
			default: begin
				// Idle, and the unused state code, which behaves as idle.
				state_n = ST_IDLE;
				if (trig && pressed) begin
					state_n              = ST_PRESSED;
					press_start_n        = first_edge_n;
					clicks_n             = bgc_pkg::CountW'(1);
					long_events_n        = '0;
					fire                 = 1'b1;
					result_n.event_kind  = bgc_pkg::EvPressed;
					result_n.click_tally = clicks_n;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_time_q     <= '0;
			last_level_q    <= 1'b1;
			edge_pending_q  <= 1'b0;
			first_edge_q    <= '0;
			last_edge_q     <= '0;
			state_q         <= ST_IDLE;
			press_start_q   <= '0;
			release_start_q <= '0;
			long_events_q   <= '0;
			clicks_q        <= '0;
			out_valid_q     <= 1'b0;
			result_q        <= '0;
		end else begin
			if (advance) begin
				tick_time_q     <= tick_time_q + 1'b1;
				last_level_q    <= pin_s1;
				edge_pending_q  <= debouncing;
				first_edge_q    <= first_edge_n;
				last_edge_q     <= last_edge_n;
				state_q         <= state_n;
				press_start_q   <= press_start_n;
				release_start_q <= release_start_n;
				long_events_q   <= long_events_n;
				clicks_q        <= clicks_n;
				out_valid_q     <= fire;
				if (fire) begin
					result_q <= result_n;
				end
			end else if (event_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
